// ===== rtl/spq_pkg.sv =====
// Shared types, constants and address helper for the sorted priority queue.
// Used by spq_ctrl and sorted_priority_queue_top; no dependencies.
package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
    localparam int PTR_W       = ADDR_W + 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    localparam logic signed [31:0] EMPTY_VALUE = -32'sd1;

    typedef struct packed {
        logic               operation;
        logic signed [31:0] item_value;
        logic signed [15:0] item_priority;
    } spq_in_t;

    typedef struct packed {
        logic signed [31:0] popped_value;
        logic [1:0]         status;
        logic [4:0]         occupancy;
    } spq_out_t;

    typedef struct packed {
        logic signed [15:0] priority_key;
        logic signed [31:0] value;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    // Logical slot offset from the head to a physical RAM address, wrapping at the depth.
    function automatic logic [ADDR_W-1:0] phys_addr(input logic [ADDR_W-1:0] base,
                                                    input logic [ADDR_W-1:0] offs);
        logic [PTR_W-1:0] sum;
        sum = {1'b0, base} + {1'b0, offs};
        if (sum >= PTR_W'(QUEUE_DEPTH)) begin
            sum = sum - PTR_W'(QUEUE_DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

// ===== rtl/spq_ram.sv =====
// Simple dual-port slot store: one write and one registered read per cycle.
// Generic; no package dependency.
module spq_ram #(
    parameter int DATA_W = 48,
    parameter int ADDR_W = 4,
    parameter int DEPTH  = 16
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/spq_ctrl.sv =====
// Queue sequencer: circular head pointer, insertion scan from the tail, result staging.
// Depends on spq_pkg; drives the slot RAM ports of spq_ram.
module spq_ctrl
    import spq_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  spq_in_t           in_data,
    output logic              res_valid,
    input  logic              res_ready,
    output spq_out_t          res_data,
    output logic              ram_wr_en,
    output logic [ADDR_W-1:0] ram_wr_addr,
    output slot_t             ram_wr_data,
    output logic              ram_rd_en,
    output logic [ADDR_W-1:0] ram_rd_addr,
    input  slot_t             ram_rd_data
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_POP_WAIT = 3'd1;
    localparam logic [2:0] ST_SCAN     = 3'd2;
    localparam logic [2:0] ST_PLACE    = 3'd3;
    localparam logic [2:0] ST_DONE     = 3'd4;

    logic [2:0]         state_reg,  state_next;
    logic [ADDR_W-1:0]  head_reg,   head_next;
    logic [CNT_W-1:0]   count_reg,  count_next;
    logic [CNT_W-1:0]   idx_reg,    idx_next;
    slot_t              item_reg,   item_next;
    logic signed [31:0] rval_reg,   rval_next;
    logic [1:0]         rstat_reg,  rstat_next;

    logic [CNT_W-1:0]   cnt_m1;
    logic [CNT_W-1:0]   idx_m1;
    logic [CNT_W-1:0]   idx_p1;
    logic               accept;

    assign cnt_m1    = count_reg - CNT_W'(1);
    assign idx_m1    = idx_reg - CNT_W'(1);
    assign idx_p1    = idx_reg + CNT_W'(1);

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign res_valid = (state_reg == ST_DONE);

    assign res_data.popped_value = rval_reg;
    assign res_data.status       = rstat_reg;
    assign res_data.occupancy    = 5'(count_reg);

    always_comb begin
        state_next  = state_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        item_next   = item_reg;
        rval_next   = rval_reg;
        rstat_next  = rstat_reg;
        ram_wr_en   = 1'b0;
        ram_wr_addr = phys_addr(head_reg, idx_p1[ADDR_W-1:0]);
        ram_wr_data = item_reg;
        ram_rd_en   = 1'b0;
        ram_rd_addr = head_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    item_next.value        = in_data.item_value;
                    item_next.priority_key = in_data.item_priority;
                    rval_next              = EMPTY_VALUE;
                    rstat_next             = STAT_DONE;
                    if (in_data.operation == OP_POP) begin
                        if (count_reg == '0) begin
                            rstat_next = STAT_EMPTY;
                            state_next = ST_DONE;
                        end else begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = head_reg;
                            state_next  = ST_POP_WAIT;
                        end
                    end else if (count_reg == CNT_W'(QUEUE_DEPTH)) begin
                        rstat_next = STAT_FULL;
                        state_next = ST_DONE;
                    end else if (count_reg == '0) begin
                        ram_wr_en                = 1'b1;
                        ram_wr_addr              = head_reg;
                        ram_wr_data.value        = in_data.item_value;
                        ram_wr_data.priority_key = in_data.item_priority;
                        count_next               = count_reg + CNT_W'(1);
                        state_next               = ST_DONE;
                    end else begin
                        // walk from the tail towards the head, one slot a cycle
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = phys_addr(head_reg, cnt_m1[ADDR_W-1:0]);
                        idx_next    = cnt_m1;
                        state_next  = ST_SCAN;
                    end
                end
            end
            ST_POP_WAIT: begin
                rval_next  = ram_rd_data.value;
                head_next  = (head_reg == ADDR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : head_reg + ADDR_W'(1);
                count_next = cnt_m1;
                state_next = ST_DONE;
            end
            ST_SCAN: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = phys_addr(head_reg, idx_p1[ADDR_W-1:0]);
                if ($signed(ram_rd_data.priority_key) > $signed(item_reg.priority_key)) begin
                    // stored entry moves back one slot
                    ram_wr_data = ram_rd_data;
                    if (idx_reg == '0) begin
                        state_next = ST_PLACE;
                    end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = phys_addr(head_reg, idx_m1[ADDR_W-1:0]);
                        idx_next    = idx_m1;
                    end
                end else begin
                    // equal or smaller key stays ahead: new entry lands just behind it
                    ram_wr_data = item_reg;
                    count_next  = count_reg + CNT_W'(1);
                    state_next  = ST_DONE;
                end
            end
            ST_PLACE: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = head_reg;
                ram_wr_data = item_reg;
                count_next  = count_reg + CNT_W'(1);
                state_next  = ST_DONE;
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg   <= idx_next;
        item_reg  <= item_next;
        rval_reg  <= rval_next;
        rstat_reg <= rstat_next;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (idx_reg < count_reg))
        else $error("scan index outside stored entries");

    a_no_rw_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_wr_en && ram_rd_en) |-> (ram_wr_addr != ram_rd_addr))
        else $error("read and write hit the same slot");

    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && rstat_reg == STAT_FULL) |-> (count_reg == CNT_W'(QUEUE_DEPTH)))
        else $error("full status with free slots");

    a_pop_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_POP_WAIT) |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("pop did not release one entry");

endmodule

// ===== rtl/sorted_priority_queue_top.sv =====
// Sorted priority queue top: sequencer, slot RAM and result register.
// Empty pop / full insert: status only; pop reads the head; insert scans and shifts slots.
// One item at a time; the insertion scan reads one RAM slot per cycle.
// A new item is taken while the previous result waits in the output register.
// Reset (aresetn, synchronous, active low) empties the queue; slot RAM is not cleared.
// Depends on spq_pkg, spq_ctrl and spq_ram.
module sorted_priority_queue_top
    import spq_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  spq_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output spq_out_t m_data
);

    logic              res_valid;
    logic              res_ready;
    spq_out_t          res_data;
    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    slot_t             ram_wr_data;
    logic              ram_rd_en;
    logic [ADDR_W-1:0] ram_rd_addr;
    slot_t             ram_rd_data;

    logic              m_valid_reg, m_valid_next;
    spq_out_t          m_data_reg;

    spq_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_data     (s_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_data    (res_data),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    spq_ram #(
        .DATA_W (SLOT_W),
        .ADDR_W (ADDR_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // output register frees up in the same cycle its transfer completes
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_data_reg <= res_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== sim/tb_sorted_priority_queue_top.sv =====
`timescale 1ns / 100ps
// Testbench for sorted_priority_queue_top: a directed table, then random inserts and pops.
// Results are checked against a behavioural queue kept in the bench. Depends on spq_pkg.
module tb_sorted_priority_queue_top;
    import spq_pkg::*;

    localparam int LONG_HOLD      = 200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 64;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 50;

    typedef struct packed {
        logic     pinned;
        spq_out_t result;
    } pinned_res_t;

    typedef struct packed {
        spq_in_t     item;
        pinned_res_t pin;
    } row_t;

    logic     aclk = 1'b0;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    spq_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    spq_out_t m_data;

    logic idle_on;
    logic long_hold_req;
    int   mismatches;

    // bench copy of the queue, head at index 0
    logic signed [31:0] queue_value [QUEUE_DEPTH];
    logic signed [15:0] queue_prio  [QUEUE_DEPTH];
    int                 queue_count;

    spq_out_t    owed_results [$];
    pinned_res_t row_pin_q [$];
    pinned_res_t pin_now;
    spq_out_t    predicted_now;

    sorted_priority_queue_top DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #2 aclk = ~aclk;

    function automatic spq_out_t apply_to_queue(spq_in_t item);
        spq_out_t res;
        int       pos;
        res.popped_value = EMPTY_VALUE;
        res.status       = STAT_DONE;
        if (item.operation == OP_POP) begin
            if (queue_count == 0) begin
                res.status = STAT_EMPTY;
            end else begin
                res.popped_value = queue_value[0];
                for (int i = 1; i < queue_count; i++) begin
                    queue_value[i-1] = queue_value[i];
                    queue_prio[i-1]  = queue_prio[i];
                end
                queue_count--;
            end
        end else if (queue_count >= QUEUE_DEPTH) begin
            res.status = STAT_FULL;
        end else begin
            // ties go behind stored entries of the same priority
            pos = 0;
            while (pos < queue_count && queue_prio[pos] <= item.item_priority) pos++;
            for (int i = queue_count; i > pos; i--) begin
                queue_value[i] = queue_value[i-1];
                queue_prio[i]  = queue_prio[i-1];
            end
            queue_value[pos] = item.item_value;
            queue_prio[pos]  = item.item_priority;
            queue_count++;
        end
        res.occupancy = 5'(queue_count);
        return res;
    endfunction

    function automatic row_t mk_row(logic op, logic signed [31:0] val, logic signed [15:0] prio,
                                    logic pinned, logic signed [31:0] res_val,
                                    logic [1:0] res_stat, logic [4:0] res_occ);
        row_t r;
        r.item.operation       = op;
        r.item.item_value      = val;
        r.item.item_priority   = prio;
        r.pin.pinned           = pinned;
        r.pin.result.popped_value = res_val;
        r.pin.result.status    = res_stat;
        r.pin.result.occupancy = res_occ;
        return r;
    endfunction

    task automatic check_result(spq_out_t got);
        spq_out_t want;
        if (owed_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: value %0d status %0d occupancy %0d",
                         got.popped_value, got.status, got.occupancy);
        end else begin
            want = owed_results.pop_front();
            if (got.popped_value !== want.popped_value || got.status !== want.status ||
                got.occupancy !== want.occupancy) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: expected value %0d status %0d occupancy %0d, ",
                              "got value %0d status %0d occupancy %0d"},
                             want.popped_value, want.status, want.occupancy,
                             got.popped_value, got.status, got.occupancy);
            end
        end
    endtask

    // transfer monitor: predict on input acceptance, compare on output acceptance
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                pin_now       = row_pin_q.pop_front();
                predicted_now = apply_to_queue(s_data);
                owed_results.push_back(pin_now.pinned ? pin_now.result : predicted_now);
            end
            if (m_valid && m_ready) check_result(m_data);
        end
    end

    always @(posedge aclk) begin : watchdog
        int stuck_cycles;
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
            if (stuck_cycles >= WATCHDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // receiver: random stall bursts, plus one long hold-off on request
    initial begin
        m_ready = 1'b0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (long_hold_req) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                long_hold_req = 1'b0;
                m_ready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 6) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic offer_item(spq_in_t item, pinned_res_t pin);
        row_pin_q.push_back(pin);
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
    endtask

    initial begin
        row_t        rows [$];
        spq_in_t     item;
        pinned_res_t no_pin;
        int          insert_pct [PHASES];
        bit          idle_phase [PHASES];

        insert_pct    = '{50, 85, 15, 90, 10, 50, 60, 40};
        idle_phase    = '{1, 1, 1, 0, 1, 1, 0, 0};
        no_pin        = '0;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        idle_on       = 1'b1;
        long_hold_req = 1'b0;
        mismatches    = 0;
        queue_count   = 0;

        rows.push_back(mk_row(OP_POP, 0, 0, 1'b1, EMPTY_VALUE, STAT_EMPTY, 5'd0));
        rows.push_back(mk_row(OP_INSERT, 32'sh7FFFFFFF, 16'sh7FFF, 1'b1, EMPTY_VALUE, STAT_DONE, 5'd1));
        rows.push_back(mk_row(OP_INSERT, 32'sh80000000, 16'sh8000, 1'b1, EMPTY_VALUE, STAT_DONE, 5'd2));
        // pop carries junk in the ignored fields
        rows.push_back(mk_row(OP_POP, -1, -1, 1'b1, 32'sh80000000, STAT_DONE, 5'd1));
        rows.push_back(mk_row(OP_INSERT, 0, 0, 1'b0, 0, 0, 0));
        rows.push_back(mk_row(OP_INSERT, 1, 0, 1'b0, 0, 0, 0));
        rows.push_back(mk_row(OP_INSERT, 2, 0, 1'b0, 0, 0, 0));
        rows.push_back(mk_row(OP_INSERT, -1, -1, 1'b0, 0, 0, 0));
        rows.push_back(mk_row(OP_INSERT, 32'sh55555555, 16'sh7FFF, 1'b0, 0, 0, 0));
        rows.push_back(mk_row(OP_INSERT, 32'shAAAAAAAA, 16'sh8000, 1'b0, 0, 0, 0));
        rows.push_back(mk_row(OP_INSERT, 11, 100, 1'b0, 0, 0, 0));
        rows.push_back(mk_row(OP_INSERT, 12, -100, 1'b0, 0, 0, 0));
        rows.push_back(mk_row(OP_INSERT, 13, 5, 1'b0, 0, 0, 0));
        rows.push_back(mk_row(OP_INSERT, 14, 5, 1'b0, 0, 0, 0));
        rows.push_back(mk_row(OP_INSERT, 15, -5, 1'b0, 0, 0, 0));
        rows.push_back(mk_row(OP_INSERT, 16, 3, 1'b0, 0, 0, 0));
        rows.push_back(mk_row(OP_INSERT, 17, 20000, 1'b0, 0, 0, 0));
        rows.push_back(mk_row(OP_INSERT, 18, 16'sh8000, 1'b0, 0, 0, 0));
        rows.push_back(mk_row(OP_INSERT, 19, 16'sh7FFF, 1'b0, 0, 0, 0));
        // queue now full: the next insert is dropped
        rows.push_back(mk_row(OP_INSERT, 20, 0, 1'b1, EMPTY_VALUE, STAT_FULL, 5'd16));
        repeat (5) rows.push_back(mk_row(OP_POP, 32'sh12345678, 16'sh5A5A, 1'b0, 0, 0, 0));

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) offer_item(rows[i].item, rows[i].pin);

        for (int p = 0; p < PHASES; p++) begin
            idle_on = idle_phase[p];
            // fill-up phase: receiver holds off while inserts keep coming
            if (p == 1) long_hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                item.operation  = ($urandom_range(0, 99) < insert_pct[p]) ? OP_INSERT : OP_POP;
                item.item_value = $urandom;
                case ($urandom_range(0, 3))
                    0, 1:    item.item_priority = 16'($urandom_range(0, 7)) - 16'sd4;
                    2:       item.item_priority = 16'($urandom);
                    default: item.item_priority = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                endcase
                offer_item(item, no_pin);
            end
        end
        s_valid <= 1'b0;

        while (owed_results.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/spq_pkg.sv
rtl/spq_ram.sv
rtl/spq_ctrl.sv
rtl/sorted_priority_queue_top.sv
sim/tb_sorted_priority_queue_top.sv
